// ===== rtl/core/assert_macros.svh =====
// assertion helpers included by the deframer top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is held
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// clocked check that also holds through reset
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/gbfd_pkg.sv =====
`timescale 1ns / 1ps
package gbfd_pkg;

    // frame size limits
    localparam int MAX_RAW_BYTES = 4096;
    localparam int LEN_W         = 12;
    localparam int CNT_W         = 13;
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_RAW_BYTES - 4);

    // sync pattern
    localparam logic [7:0]  SYNC_A       = 8'hAA;
    localparam logic [7:0]  SYNC_B       = 8'h44;
    localparam logic [15:0] SYNC_AB      = {SYNC_A, SYNC_B};
    localparam logic [7:0]  SYNC_C_VAR_A = 8'h12;
    localparam logic [7:0]  SYNC_C_VAR_B = 8'hB5;

    // header sizes added to the length field
    localparam logic [16:0] HDR_LEN_A = 17'd28;
    localparam logic [16:0] HDR_LEN_B = 17'd24;

    // byte positions within the frame
    localparam logic [CNT_W-1:0] IDX_TYPE_LO  = CNT_W'(4);
    localparam logic [CNT_W-1:0] IDX_TYPE_HI  = CNT_W'(5);
    localparam logic [CNT_W-1:0] IDX_LEN_LO_B = CNT_W'(6);
    localparam logic [CNT_W-1:0] IDX_LEN_HI_B = CNT_W'(7);
    localparam logic [CNT_W-1:0] IDX_LEN_LO_A = CNT_W'(8);
    localparam logic [CNT_W-1:0] IDX_LEN_HI_A = CNT_W'(9);
    localparam logic [CNT_W-1:0] IDX_BODY     = CNT_W'(10);
    localparam logic [CNT_W-1:0] CNT_SYNCED   = CNT_W'(3);
    localparam logic [CNT_W-1:0] CRC_BYTES    = CNT_W'(4);

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;

    typedef enum logic [1:0] {
        ST_LEN_ERR = 2'd0,
        ST_CRC_ERR = 2'd1,
        ST_GOOD    = 2'd2
    } t_status;

    // one result word from the frame tracker
    typedef struct packed {
        logic             emit;
        t_status          status;
        logic [15:0]      msg_type;
        logic [LEN_W-1:0] bytes;
        logic             variant;
    } t_result;

    // reflected crc-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] t;
        t = {24'd0, crc[7:0] ^ b};
        for (int k = 0; k < 8; k++) begin
            t = t[0] ? ((t >> 1) ^ CRC_POLY) : (t >> 1);
        end
        return {8'd0, crc[31:8]} ^ t;
    endfunction

    // crc after the three sync bytes
    localparam logic [31:0] CRC_SEED_A =
        crc_byte(crc_byte(crc_byte(32'd0, SYNC_A), SYNC_B), SYNC_C_VAR_A);
    localparam logic [31:0] CRC_SEED_B =
        crc_byte(crc_byte(crc_byte(32'd0, SYNC_A), SYNC_B), SYNC_C_VAR_B);

endpackage

// ===== rtl/core/gbfd_frame_track.sv =====
`timescale 1ns / 1ps
module gbfd_frame_track (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [7:0]       i_byte,
    output gbfd_pkg::t_result o_result
);
    import gbfd_pkg::*;

    logic [15:0]      r_window,  n_window;
    logic [CNT_W-1:0] r_count,   n_count;
    logic [LEN_W-1:0] r_len,     n_len;
    logic             r_variant, n_variant;
    logic [31:0]      r_crc,     n_crc;
    logic [31:0]      r_rcv,     n_rcv;
    logic [15:0]      r_type,    n_type;
    logic [7:0]       r_len_low, n_len_low;

    logic [CNT_W-1:0] w_cnt_inc;
    logic [16:0]      w_len_sum;
    logic             w_len_lo;
    logic             w_len_hi;

    assign w_cnt_inc = r_count + CNT_W'(1);
    assign w_len_sum = {1'b0, i_byte, r_len_low} + (r_variant ? HDR_LEN_B : HDR_LEN_A);
    assign w_len_lo  = r_variant ? (r_count == IDX_LEN_LO_B) : (r_count == IDX_LEN_LO_A);
    assign w_len_hi  = r_variant ? (r_count == IDX_LEN_HI_B) : (r_count == IDX_LEN_HI_A);

    // sync hunt, byte counting, crc and frame end
    always_comb begin
        n_window  = r_window;
        n_count   = r_count;
        n_len     = r_len;
        n_variant = r_variant;
        n_crc     = r_crc;
        n_rcv     = r_rcv;
        n_type    = r_type;
        n_len_low = r_len_low;
        o_result  = '0;
        if (i_en) begin
            if (r_count == '0) begin
                n_window = {r_window[7:0], i_byte};
                if (r_window == SYNC_AB &&
                    (i_byte == SYNC_C_VAR_A || i_byte == SYNC_C_VAR_B)) begin
                    n_variant = (i_byte == SYNC_C_VAR_B);
                    n_crc     = (i_byte == SYNC_C_VAR_B) ? CRC_SEED_B : CRC_SEED_A;
                    n_rcv     = '0;
                    n_count   = CNT_SYNCED;
                end
            end else begin
                n_count = w_cnt_inc;
                // crc over header and body, then collect the trailing crc
                if (r_count < IDX_BODY || r_count < {1'b0, r_len}) begin
                    n_crc = crc_byte(r_crc, i_byte);
                end else begin
                    n_rcv = {i_byte, r_rcv[31:8]};
                end
                if (r_count == IDX_TYPE_LO) begin
                    n_type = {8'd0, i_byte};
                end else if (r_count == IDX_TYPE_HI) begin
                    n_type = {i_byte, r_type[7:0]};
                end
                if (w_len_lo) begin
                    n_len_low = i_byte;
                end
                if (w_len_hi) begin
                    n_len = w_len_sum[LEN_W-1:0];
                end
                o_result.msg_type = n_type;
                o_result.variant  = r_variant;
                // drop an oversize frame at once
                priority if (w_len_hi && w_len_sum > {5'd0, LEN_LIMIT}) begin
                    n_count         = '0;
                    o_result.emit   = 1'b1;
                    o_result.status = ST_LEN_ERR;
                    o_result.bytes  = LEN_LIMIT;
                end else if (w_cnt_inc >= IDX_BODY &&
                             w_cnt_inc >= ({1'b0, n_len} + CRC_BYTES)) begin
                    n_count         = '0;
                    o_result.emit   = 1'b1;
                    o_result.status = (n_crc == n_rcv) ? ST_GOOD : ST_CRC_ERR;
                    o_result.bytes  = n_len;
                end else begin
                    // frame still running, no word out
                    o_result.emit   = 1'b0;
                end
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_count  <= '0;
        end else begin
            r_window <= n_window;
            r_count  <= n_count;
        end
    end

    // frame fields
    always_ff @(posedge i_clk) begin
        r_len     <= n_len;
        r_variant <= n_variant;
        r_crc     <= n_crc;
        r_rcv     <= n_rcv;
        r_type    <= n_type;
        r_len_low <= n_len_low;
    end

endmodule

// ===== rtl/core/gnss_binary_frame_deframer_top.sv =====
`timescale 1ns / 1ps
// channel   direction  handshake          payload
// input     in         i_valid / o_stall  i_data_byte[7:0]
// result    out        o_valid / i_stall  o_frame_status, o_message_type,
//                                         o_frame_bytes, o_header_variant
//
// one byte per cycle sustained while no stalled result waits; a result is presented
// from the result register once the byte that ends or drops the frame has passed
// through the input register; the bytewise crc-32 update sets the timing of the path
// from the input to the result register; synchronous active-low reset returns the block to sync hunting
// input stalls only while a result waits under a downstream stall
`include "assert_macros.svh"
module gnss_binary_frame_deframer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_frame_status,
    output logic [15:0] o_message_type,
    output logic [11:0] o_frame_bytes,
    output logic        o_header_variant
);
    import gbfd_pkg::*;

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_out_valid;
    t_status          r_status;
    logic [15:0]      r_msg_type;
    logic [LEN_W-1:0] r_bytes;
    logic             r_variant;

    logic             w_proc_en;
    logic             w_load_in;
    t_result          w_result;

    // a byte moves on unless a waiting result is stalled
    assign w_proc_en = r_in_valid && (!r_out_valid || !i_stall);
    assign w_load_in = !r_in_valid || w_proc_en;
    assign o_stall   = !w_load_in;

    gbfd_frame_track u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_proc_en),
        .i_byte   (r_in_byte),
        .o_result (w_result)
    );

    // input word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_load_in) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_in) begin
            r_in_byte <= i_data_byte;
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proc_en) begin
            r_out_valid <= w_result.emit;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc_en && w_result.emit) begin
            r_status   <= w_result.status;
            r_msg_type <= w_result.msg_type;
            r_bytes    <= w_result.bytes;
            r_variant  <= w_result.variant;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_frame_status   = r_status;
    assign o_message_type   = r_msg_type;
    assign o_frame_bytes    = r_bytes;
    assign o_header_variant = r_variant;

    // checks
    `ASSERT_CLK_RST(a_result_from_byte, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(w_proc_en), "result word without a processed byte")
    `ASSERT_CLK_RST(a_len_err_saturates, i_clk, i_rst_n, (r_out_valid && r_status == ST_LEN_ERR) |-> (r_bytes == LEN_LIMIT), "oversize frame not reported at limit")
    `ASSERT_CLK_RST(a_frame_min_len, i_clk, i_rst_n, (r_out_valid && r_status != ST_LEN_ERR) |-> (r_bytes >= LEN_W'(24)), "complete frame shorter than its header")
    `ASSERT_CLK(a_stall_needs_word, i_clk, o_stall |-> r_in_valid, "input stalled with empty input register")

endmodule
